// ===== hdl/chash_pkg.sv =====
// package for the chained hash table: sizes, field types and request codes
// shared by the node store and the top level; depends on nothing else
package chash_pkg;

    localparam int TABLE_SIZE = 64;                    // a power of two
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W      = 31;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0] t_cnt;

    // request kinds carried on the input tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // one pool node: key and link to the next older node of its bucket
    typedef struct packed {
        t_key key;
        t_idx nxt;
        logic nxt_vld;
    } t_node;

    // access request to the node store
    typedef struct packed {
        logic  wr_en;
        t_idx  wr_addr;
        t_node wr_data;
        logic  rd_en;
        t_idx  rd_addr;
    } t_node_req;

endpackage

// ===== hdl/chained_hash_table.sv =====
// chained hash set with a fixed node pool, top level
// uses chash_pkg and the node store chash_nodes
//
// usage:
//   input channel: i_s_tdata carries the key, i_s_tuser the request kind
//   (insert or search). one result item per request on the output channel.
//   an insert takes the next free pool node and prepends it to the chain of
//   bucket key mod TABLE_SIZE; it is dropped once TABLE_SIZE keys are stored.
//   a search walks the bucket chain, one node per node-memory read.
//   sequence: an insert goes from accept through S_HEAD to S_OUT, which loads
//   the result register, and then back to S_IDLE for the next item. a search
//   also passes S_WALK once per chain node visited before S_OUT, and S_OUT
//   waits while the output register is still held; the single read port of
//   the node memory paces the walk. one item is worked on at a time;
//   o_s_tready is high whenever no item is in progress.
//   reset clears all bucket valid bits and the key count at once, so there
//   is no clearing pass; the node memory itself is never cleared.
//   a stalled receiver holds the result in the output register; one more
//   item can be processed meanwhile and waits until the register frees.
module chained_hash_table
    import chash_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [30:0] key, [31] zero
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [30:0] match_key, [37:31] entry_total, [39:38] zero
    output logic [1:0]  o_m_tuser    // [0] found, [1] inserted
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_OUT
    } t_state;

    t_state          r_state;
    logic            r_req;
    t_key            r_key;
    t_idx            r_bucket;
    t_cnt            r_count;
    logic [TABLE_SIZE-1:0] r_head_vld;
    t_idx            r_head_mem [TABLE_SIZE];
    t_idx            r_head_rd;
    logic            r_hvld;
    logic            r_found;
    logic            r_ins;
    t_key            r_match;
    logic            r_out_valid;
    logic [39:0]     r_out_tdata;
    logic [1:0]      r_out_tuser;

    logic            in_acc;
    t_key            in_key;
    t_idx            in_bucket;
    logic            head_we;
    logic            has_room;
    logic            out_free;
    t_node_req       node_req;
    t_node           node_rd;

    assign in_key    = i_s_tdata[KEY_W-1:0];
    assign in_bucket = in_key[IDX_W-1:0];
    assign in_acc    = i_s_tvalid && o_s_tready;
    assign has_room  = r_count < CNT_W'(TABLE_SIZE);
    assign head_we   = (r_state == S_HEAD) && (r_req == REQ_INSERT) && has_room;
    assign out_free  = !r_out_valid || i_m_tready;

    // node store accesses: write on insert, read at head or along the chain
    always_comb begin
        node_req                 = '0;
        node_req.wr_en           = head_we;
        node_req.wr_addr         = r_count[IDX_W-1:0];
        node_req.wr_data.key     = r_key;
        node_req.wr_data.nxt     = r_head_rd;
        node_req.wr_data.nxt_vld = r_hvld;
        if (r_state == S_HEAD) begin
            node_req.rd_en   = (r_req == REQ_SEARCH) && r_hvld;
            node_req.rd_addr = r_head_rd;
        end else if (r_state == S_WALK) begin
            node_req.rd_en   = (node_rd.key != r_key) && node_rd.nxt_vld;
            node_req.rd_addr = node_rd.nxt;
        end
    end

    chash_nodes u_nodes (
        .i_clk     (i_clk),
        .i_req     (node_req),
        .o_rd_data (node_rd)
    );

    // bucket head memory with registered read
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[r_bucket] <= r_count[IDX_W-1:0];
        end
        if (in_acc) begin
            r_head_rd <= r_head_mem[in_bucket];
        end
    end

    // request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req    <= i_s_tuser;
                        r_key    <= in_key;
                        r_bucket <= in_bucket;
                        r_hvld   <= r_head_vld[in_bucket];
                        r_state  <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_found <= 1'b0;
                    r_match <= '0;
                    r_ins   <= 1'b0;
                    if (r_req == REQ_INSERT) begin
                        if (has_room) begin
                            r_head_vld[r_bucket] <= 1'b1;
                            r_count              <= r_count + 1'b1;
                            r_ins                <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end else if (r_hvld) begin
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_WALK: begin
                    // links point to older nodes, so the walk ends
                    if (node_rd.key == r_key) begin
                        r_found <= 1'b1;
                        r_match <= r_key;
                        r_state <= S_OUT;
                    end else if (!node_rd.nxt_vld) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_tdata <= {2'b00, r_count, r_match};
                        r_out_tuser <= {r_ins, r_found};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    // key count never passes the pool size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_SIZE))
        else $error("key count above pool size");

    // key count never falls outside reset
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(i_rst_n) |=> r_count >= $past(r_count))
        else $error("key count decreased");

    // a result is never both a hit and an insertion
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("found and inserted both set");

    // a miss reports a zero match key
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[KEY_W-1:0] == '0))
        else $error("match key nonzero on a miss");

    // an accepted item always goes to the head lookup next
    a_acc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_HEAD))
        else $error("accepted item skipped head lookup");

endmodule

// ===== hdl/chash_nodes.sv =====
// node pool memory of the chained hash table: one write and one read port,
// read data registered; depends on chash_pkg
module chash_nodes
    import chash_pkg::*;
(
    input  logic      i_clk,
    input  t_node_req i_req,
    output t_node     o_rd_data
);

    t_node r_mem [TABLE_SIZE];
    t_node r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
